[hdl/sha1_pkg.sv]
// Shared types, constants and helper functions of the SHA-1 engine.
package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int BlockBytes = 64;
    localparam int LenOffset  = 56;
    localparam int Rounds     = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    localparam word_t H0_INIT = 32'h67452301;
    localparam word_t H1_INIT = 32'hefcdab89;
    localparam word_t H2_INIT = 32'h98badcfe;
    localparam word_t H3_INIT = 32'h10325476;
    localparam word_t H4_INIT = 32'hc3d2e1f0;

    // Commands from the sequencer to the schedule window and the round unit.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       load;
        logic       round;
        logic [6:0] round_idx;
        logic       add;
        logic       restart;
    } ctrl_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

[hdl/sha1_sched.sv]
// Message schedule window: takes bytes in, then expands W one word per round.
module sha1_sched (
    input  logic                   clk,
    input  sha1_pkg::ctrl_t        ctrl,
    output sha1_pkg::word_t        w_top
);
    import sha1_pkg::*;

    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_new;

    // Word j of the window is W[t+j] during round t.
    assign w_new = rotl(win_reg[511-13*32 -: 32] ^ win_reg[511-8*32 -: 32]
                        ^ win_reg[511-2*32 -: 32] ^ win_reg[511 -: 32], 1);

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.push)
        begin
            win_next = {win_reg[503:0], ctrl.push_byte};
        end
        else if (ctrl.round)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign w_top = win_reg[511 -: 32];

endmodule

[hdl/sha1_round.sv]
// Shared round unit with the working variables and the chaining words.
module sha1_round (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::ctrl_t     ctrl,
    input  sha1_pkg::word_t     w_top,
    input  logic [2:0]          sel,
    output sha1_pkg::word_t     chain_word
);
    import sha1_pkg::*;

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    word_t f_val;
    word_t k_val;
    word_t t_val;

    always_comb
    begin
        if (ctrl.round_idx < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (ctrl.round_idx < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (ctrl.round_idx < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = rotl(a_reg, 5) + f_val + e_reg + k_val + w_top;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
            e_reg <= h4_reg;
        end
        else if (ctrl.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg <= H0_INIT;
            h1_reg <= H1_INIT;
            h2_reg <= H2_INIT;
            h3_reg <= H3_INIT;
            h4_reg <= H4_INIT;
        end
        else if (ctrl.restart)
        begin
            h0_reg <= H0_INIT;
            h1_reg <= H1_INIT;
            h2_reg <= H2_INIT;
            h3_reg <= H3_INIT;
            h4_reg <= H4_INIT;
        end
        else if (ctrl.add)
        begin
            h0_reg <= h0_reg + a_reg;
            h1_reg <= h1_reg + b_reg;
            h2_reg <= h2_reg + c_reg;
            h3_reg <= h3_reg + d_reg;
            h4_reg <= h4_reg + e_reg;
        end
    end

    always_comb
    begin
        case (sel)
            3'd0:    chain_word = h0_reg;
            3'd1:    chain_word = h1_reg;
            3'd2:    chain_word = h2_reg;
            3'd3:    chain_word = h3_reg;
            default: chain_word = h4_reg;
        endcase
    end

endmodule

[hdl/sha1_ctrl.sv]
// Sequencer: byte fill, padding, round counting and digest readout.
module sha1_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  logic                op,
    input  logic [7:0]          data_byte,
    output logic                dig_valid,
    input  logic                dig_ready,
    output logic [2:0]          word_index,
    output logic                last,
    output sha1_pkg::ctrl_t     ctrl
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PADZ   = 3'd1;
    localparam logic [2:0] S_PADLEN = 3'd2;
    localparam logic [2:0] S_COMP   = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [5:0] FILL_LAST = 6'(BlockBytes - 1);
    localparam logic [5:0] FILL_LEN  = 6'(LenOffset);
    localparam logic [6:0] RND_LAST  = 7'(Rounds - 1);

    logic [2:0]  state_reg, state_next;
    logic [2:0]  ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] bcnt_reg, bcnt_next;
    logic [2:0]  len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  widx_reg, widx_next;
    logic [63:0] len_shifted;

    assign len_shifted = {bcnt_reg, 3'b000} << {len_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        bcnt_next  = bcnt_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        ctrl       = '0;
        ctrl.round_idx = rnd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    ctrl.push      = 1'b1;
                    ctrl.push_byte = op ? PAD_BYTE : data_byte;
                    if (!op)
                    begin
                        bcnt_next = bcnt_reg + 61'd1;
                    end
                    ret_next   = op ? S_PADZ : S_IDLE;
                    state_next = op ? S_PADZ : S_IDLE;
                end
            end
            S_PADZ:
            begin
                if (fill_reg == FILL_LEN)
                begin
                    len_next   = '0;
                    state_next = S_PADLEN;
                end
                else
                begin
                    ctrl.push      = 1'b1;
                    ctrl.push_byte = 8'h00;
                    ret_next       = S_PADZ;
                end
            end
            S_PADLEN:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = len_shifted[63:56];
                len_next       = len_reg + 3'd1;
                ret_next       = S_OUT;
            end
            S_COMP:
            begin
                ctrl.round = 1'b1;
                rnd_next   = rnd_reg + 7'd1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                ctrl.add   = 1'b1;
                widx_next  = '0;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (dig_ready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd4)
                    begin
                        ctrl.restart = 1'b1;
                        fill_next    = '0;
                        bcnt_next    = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A full buffer starts a compression, then resumes where it left off.
        if (ctrl.push)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == FILL_LAST)
            begin
                ctrl.load  = 1'b1;
                rnd_next   = '0;
                state_next = S_COMP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= '0;
            bcnt_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            bcnt_reg  <= bcnt_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
        end
    end

    assign msg_ready  = (state_reg == S_IDLE);
    assign dig_valid  = (state_reg == S_OUT);
    assign word_index = widx_reg;
    assign last       = (widx_reg == 3'd4);

endmodule

[hdl/sha1_hash_engine.sv]
// Top level of the byte-serial SHA-1 engine.
//
// Requests arrive on msg_valid/msg_ready with op and data_byte. An absorb
// request (op = 0) adds one byte; a finish request (op = 1) pads the message
// and returns the digest as five words on dig_valid/dig_ready, first word
// first, with word_index 0..4 and last set on the fifth word.
// Byte storage is a 512-bit schedule window; one shared round unit runs the
// 80 rounds, one per cycle, followed by the chaining add. An absorb request
// that fills the block starts a compression; msg_ready is low until it ends.
// A finish request pushes the padding bytes one by one (9 to 72, the 0x80
// byte included), with an idle step before the length bytes, and runs one
// or two compressions; then the five words are offered.
// msg_ready is low from an accepted finish until the last word is taken;
// a stalled receiver holds the current word and the engine simply waits.
// Reset, and the taking of the last digest word, return the chaining words
// to the initial values and clear the byte and length counts.
module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        dig_valid,
    input  logic        dig_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);
    import sha1_pkg::*;

    ctrl_t ctrl;
    word_t w_top;

    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .op         (op),
        .data_byte  (data_byte),
        .dig_valid  (dig_valid),
        .dig_ready  (dig_ready),
        .word_index (word_index),
        .last       (last),
        .ctrl       (ctrl)
    );

    sha1_sched u_sched (
        .clk   (clk),
        .ctrl  (ctrl),
        .w_top (w_top)
    );

    sha1_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .w_top      (w_top),
        .sel        (word_index),
        .chain_word (digest_word)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && dig_valid))
        else $error("request and digest channels active together");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (last == (word_index == 3'd4)))
        else $error("last flag does not match word index");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && dig_ready && last) |=> msg_ready)
        else $error("engine not ready after final digest word");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dig_valid) |-> (word_index == 3'd0))
        else $error("digest readout does not start at word zero");

endmodule

[bench/sha1_hash_engine_tb.sv]
// Self-checking testbench for the byte-serial SHA-1 engine with a built-in digest predictor.
module sha1_hash_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int MAX_IDLE_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 400;
    localparam int LONG_HOLD       = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int TARGET_REQUESTS = 200;

    typedef struct {
        logic       op_bit;
        logic [7:0] payload;
        bit         drain;
    } msg_request_t;

    typedef struct {
        word_t      word;
        logic [2:0] pos;
        logic       is_last;
    } digest_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_ready;
    logic        op = OP_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        dig_valid;
    logic        dig_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    msg_request_t  request_q [$];
    digest_entry_t digest_q [$];
    msg_request_t  head;
    digest_entry_t got;
    int            queued_requests = 0;
    int            results_pending = 0;
    int            mismatch_count = 0;
    int            idle_cycles = 0;

    // Driver and receiver bookkeeping, touched only inside their own processes.
    bit send_burst;
    bit sent_now;
    int send_wait;
    bit take_burst;
    int take_wait;
    int hold_left;
    int words_taken;

    // Predicted engine state.
    word_t       hash_state [5];
    logic [7:0]  pending_block [64];
    int unsigned block_fill;
    logic [60:0] msg_len_bytes;

    sha1_hash_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .op          (op),
        .data_byte   (data_byte),
        .dig_valid   (dig_valid),
        .dig_ready   (dig_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

    always #5 clk = ~clk;

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic restart_hash();
        hash_state[0] = H0_INIT;
        hash_state[1] = H1_INIT;
        hash_state[2] = H2_INIT;
        hash_state[3] = H3_INIT;
        hash_state[4] = H4_INIT;
        block_fill    = 0;
        msg_len_bytes = '0;
    endtask

    task automatic run_compression();
        word_t w [80];
        word_t a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {pending_block[4*r], pending_block[4*r+1],
                    pending_block[4*r+2], pending_block[4*r+3]};
        for (int r = 16; r < Rounds; r++)
        begin
            t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < Rounds; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endtask

    task automatic feed_block_byte(input logic [7:0] value);
        pending_block[block_fill] = value;
        block_fill++;
        if (block_fill == BlockBytes)
        begin
            run_compression();
            block_fill = 0;
        end
    endtask

    // Pads the message, runs the final compressions, queues the five digest words and restarts the predictor.
    task automatic finish_digest();
        logic [63:0]   bit_len;
        digest_entry_t entry;
        bit_len = {msg_len_bytes, 3'b000};
        feed_block_byte(PAD_BYTE);
        while (block_fill != LenOffset)
            feed_block_byte(8'h00);
        for (int i = 0; i < 8; i++)
            feed_block_byte(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++)
        begin
            entry.word    = hash_state[i];
            entry.pos     = 3'(i);
            entry.is_last = (i == 4);
            digest_q.push_back(entry);
        end
        restart_hash();
    endtask

    task automatic add_request(input logic op_bit, input logic [7:0] value, input bit drain);
        msg_request_t req;
        req.op_bit  = op_bit;
        req.payload = value;
        req.drain   = drain;
        request_q.push_back(req);
        queued_requests++;
    endtask

    // A message of random bytes followed by a finish request with a random, ignored byte.
    task automatic add_message(input int len, input bit drain);
        for (int i = 0; i < len; i++)
            add_request(OP_ABSORB, 8'($urandom_range(0, 255)), drain && i == 0);
        add_request(OP_FINISH, 8'($urandom_range(0, 255)), drain && len == 0);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid  <= 1'b0;
            op         <= OP_ABSORB;
            data_byte  <= 8'h00;
            send_wait  = 0;
            send_burst = 0;
        end
        else
        begin
            sent_now = msg_valid && msg_ready;
            if (sent_now)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 10);
            end
            if (!msg_valid || sent_now)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    msg_valid <= 1'b0;
                end
                else if (request_q.size() == 0)
                    msg_valid <= 1'b0;
                // A draining request waits until every digest word has been taken.
                else if (request_q[0].drain && (results_pending != 0 || sent_now))
                    msg_valid <= 1'b0;
                else
                begin
                    head = request_q.pop_front();
                    op        <= head.op_bit;
                    data_byte <= head.payload;
                    msg_valid <= 1'b1;
                end
            end
        end
    end

    // Digest receiver with random stalls and two long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_ready   <= 1'b0;
            take_wait   = 0;
            take_burst  = 0;
            hold_left   = 0;
            words_taken = 0;
        end
        else
        begin
            if (dig_valid && dig_ready)
            begin
                words_taken++;
                if ($urandom_range(0, 15) == 0)
                    take_burst = !take_burst;
                if (words_taken == 7 || words_taken == 37)
                    hold_left = LONG_HOLD;
                else
                    take_wait = take_burst ? 0 : $urandom_range(0, 10);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
                dig_ready <= 1'b0;
            end
            else
                dig_ready <= 1'b1;
        end
    end

    // Monitor: updates the predictor on each accepted request and checks each digest word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_valid && msg_ready)
            begin
                if (op == OP_FINISH)
                    finish_digest();
                else
                begin
                    feed_block_byte(data_byte);
                    msg_len_bytes = msg_len_bytes + 61'd1;
                end
            end
            if (dig_valid && dig_ready)
            begin
                if (digest_q.size() == 0)
                    note_failure($sformatf("Unexpected digest word %08h index %0d last %0b",
                                           digest_word, word_index, last));
                else
                begin
                    got = digest_q.pop_front();
                    if (digest_word !== got.word || word_index !== got.pos
                        || last !== got.is_last)
                        note_failure($sformatf(
                            "Digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                            got.word, got.pos, got.is_last, digest_word, word_index, last));
                end
            end
            results_pending <= digest_q.size();
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_valid && msg_ready) || (dig_valid && dig_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= MAX_IDLE_CYCLES)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        restart_hash();
        foreach (pending_block[i])
            pending_block[i] = 8'h00;

        // Empty message, with an all-ones byte that must be ignored.
        add_request(OP_FINISH, 8'hff, 1'b0);
        // "abc", held back until the previous digest has drained.
        add_request(OP_ABSORB, 8'h61, 1'b1);
        add_request(OP_ABSORB, 8'h62, 1'b0);
        add_request(OP_ABSORB, 8'h63, 1'b0);
        add_request(OP_FINISH, 8'h00, 1'b0);
        add_request(OP_ABSORB, 8'h00, 1'b0);
        add_request(OP_ABSORB, 8'hff, 1'b0);
        add_request(OP_FINISH, 8'h5a, 1'b0);
        // Back-to-back empty messages.
        add_request(OP_FINISH, 8'h00, 1'b0);
        add_request(OP_FINISH, 8'ha5, 1'b0);
        add_request(OP_ABSORB, 8'h80, 1'b0);
        add_request(OP_FINISH, 8'h01, 1'b0);

        // Length boundaries: padding fits one block, padding spills into a
        // second block, and a full block compressed on the last absorb.
        add_message(55, 1'b0);
        add_message($urandom_range(0, 3), 1'b0);
        add_message(56, 1'b0);
        add_message($urandom_range(0, 3), 1'b1);
        add_message(64, 1'b0);
        while (queued_requests < TARGET_REQUESTS)
            add_message($urandom_range(0, 8), $urandom_range(0, 7) == 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || msg_valid || results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (digest_q.size() != 0)
            note_failure($sformatf("%0d digest words never arrived", digest_q.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
